>>> src/vci_pkg.sv
`timescale 1ns / 1ps
package vci_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Divider geometry: quotient bits kept, effective mass width, dividend width
    localparam int QUO_W = 34;
    localparam int K_W   = 54;
    localparam int REM_W = 63;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION       = 3'd0,
        REG_DESIRED_SPEED   = 3'd1,
        REG_MIN_IMPULSE     = 3'd2,
        REG_CONTACT_POINT   = 3'd3,
        REG_RIGID_THRESHOLD = 3'd4
    } cfg_reg_t;

    // Request fields that ride alongside the divider stages
    typedef struct packed {
        logic signed [31:0] old;
        logic               err_pos;
        logic               rigid;
        logic               ovf;
    } div_side_t;

endpackage

>>> src/velocity_constraint_impulse.sv
`timescale 1ns / 1ps
// Velocity constraint impulse: one sequential-impulse step per request.
// Pipeline: 8 front stages, 34 restoring-divider stages at one quotient bit
// each and 2 back stages, all registered, from input acceptance to result valid.
// Throughput: one request per cycle; a stalled output holds the whole pipeline.
// Reset (rst_n, async, active low) empties the pipeline and restores the
// configuration registers to their defaults.
module velocity_constraint_impulse
    import vci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           a_mass_inertia,
    input  logic [47:0]           a_position,
    input  logic [63:0]           a_rotation,
    input  logic [47:0]           a_velocity,
    input  logic [47:0]           a_spin,
    input  logic [63:0]           b_mass_inertia,
    input  logic [47:0]           b_position,
    input  logic [63:0]           b_rotation,
    input  logic [47:0]           b_velocity,
    input  logic [47:0]           b_spin,
    input  logic signed [31:0]    impulse_sum_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    impulse_x,
    output logic signed [31:0]    impulse_y,
    output logic signed [31:0]    impulse_z,
    output logic signed [31:0]    impulse_sum_out,
    output logic                  rigid_flag
);

    localparam logic signed [33:0] ROT_ONE    = 34'sd268435456;
    localparam logic signed [55:0] SAT_MAX56  = 56'sd2147483647;
    localparam logic signed [55:0] SAT_MIN56  = -56'sd2147483648;
    localparam logic signed [35:0] SAT_MAX36  = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN36  = -36'sd2147483648;
    localparam logic signed [48:0] SAT_MAX49  = 49'sd2147483647;
    localparam logic signed [48:0] SAT_MIN49  = -49'sd2147483648;
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    // Quaternion product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_ZW = 4;
    localparam int P_XZ = 5;
    localparam int P_YW = 6;
    localparam int P_YZ = 7;
    localparam int P_XW = 8;

    function automatic logic signed [19:0] rot_diag(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [33:0] t;
        t = ROT_ONE - ((34'(a) + 34'(b)) <<< 1);
        return t[33:14];
    endfunction

    function automatic logic signed [19:0] rot_off(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic               add);
        logic signed [33:0] t;
        t = add ? ((34'(a) + 34'(b)) <<< 1) : ((34'(a) - 34'(b)) <<< 1);
        return t[33:14];
    endfunction

    function automatic logic signed [33:0] cross_term(input logic signed [16:0] a1,
                                                      input logic signed [16:0] b2,
                                                      input logic signed [16:0] a2,
                                                      input logic signed [16:0] b1);
        return 34'(a1) * 34'(b2) - 34'(a2) * 34'(b1);
    endfunction

    function automatic logic [31:0] sat_abs(input logic signed [55:0] up);
        logic signed [55:0] t;
        t = up >>> 14;
        if (t > SAT_MAX56)
            return 32'h7fff_ffff;
        else if (t < SAT_MIN56)
            return 32'h8000_0000;
        else if (t < 0)
            return 32'(-t);
        else
            return 32'(t);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0]        direction_reg;
    logic signed [31:0] desired_speed_reg;
    logic signed [31:0] min_impulse_reg;
    logic [47:0]        contact_point_reg;
    logic [31:0]        rigid_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg       <= 48'd256;
            desired_speed_reg   <= '0;
            min_impulse_reg     <= '0;
            contact_point_reg   <= '0;
            rigid_threshold_reg <= 32'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DIRECTION:       direction_reg       <= cfg_data;
                REG_DESIRED_SPEED:   desired_speed_reg   <= cfg_data[31:0];
                REG_MIN_IMPULSE:     min_impulse_reg     <= cfg_data[31:0];
                REG_CONTACT_POINT:   contact_point_reg   <= cfg_data;
                REG_RIGID_THRESHOLD: rigid_threshold_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a result waits
    // ------------------------------------------------------------------
    logic adv;
    logic s10_valid_reg;

    assign adv      = !(s10_valid_reg && out_stall);
    assign in_stall = !adv;

    // Lane views
    logic signed [15:0] dir_l [3];
    logic signed [15:0] cp_l  [3];
    logic signed [15:0] pos_l [2][3];
    logic signed [15:0] vel_l [2][3];
    logic signed [15:0] spn_l [2][3];
    logic signed [15:0] q_l   [2][4];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir_l[i]    = direction_reg[16*i +: 16];
            cp_l[i]     = contact_point_reg[16*i +: 16];
            pos_l[0][i] = a_position[16*i +: 16];
            pos_l[1][i] = b_position[16*i +: 16];
            vel_l[0][i] = a_velocity[16*i +: 16];
            vel_l[1][i] = b_velocity[16*i +: 16];
            spn_l[0][i] = a_spin[16*i +: 16];
            spn_l[1][i] = b_spin[16*i +: 16];
        end
        for (int i = 0; i < 4; i++)
        begin
            q_l[0][i] = a_rotation[16*i +: 16];
            q_l[1][i] = b_rotation[16*i +: 16];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: lever arms, velocity difference, quaternion products
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic signed [16:0] s1_r_reg  [2][3];
    logic signed [16:0] s1_r_next [2][3];
    logic signed [16:0] s1_dv_reg  [3];
    logic signed [16:0] s1_dv_next [3];
    logic signed [15:0] s1_w_reg  [2][3];
    logic signed [31:0] s1_qp_reg  [2][9];
    logic signed [31:0] s1_qp_next [2][9];
    logic [63:0]        s1_mass_reg [2];
    logic signed [31:0] s1_old_reg;

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_r_next[b][i] = 17'(cp_l[i]) - 17'(pos_l[b][i]);
            end
            s1_qp_next[b][P_XX] = 32'(q_l[b][0]) * 32'(q_l[b][0]);
            s1_qp_next[b][P_YY] = 32'(q_l[b][1]) * 32'(q_l[b][1]);
            s1_qp_next[b][P_ZZ] = 32'(q_l[b][2]) * 32'(q_l[b][2]);
            s1_qp_next[b][P_XY] = 32'(q_l[b][0]) * 32'(q_l[b][1]);
            s1_qp_next[b][P_ZW] = 32'(q_l[b][2]) * 32'(q_l[b][3]);
            s1_qp_next[b][P_XZ] = 32'(q_l[b][0]) * 32'(q_l[b][2]);
            s1_qp_next[b][P_YW] = 32'(q_l[b][1]) * 32'(q_l[b][3]);
            s1_qp_next[b][P_YZ] = 32'(q_l[b][1]) * 32'(q_l[b][2]);
            s1_qp_next[b][P_XW] = 32'(q_l[b][0]) * 32'(q_l[b][3]);
        end
        for (int i = 0; i < 3; i++)
        begin
            s1_dv_next[i] = 17'(vel_l[1][i]) - 17'(vel_l[0][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_r_reg       <= s1_r_next;
            s1_dv_reg      <= s1_dv_next;
            s1_w_reg       <= spn_l;
            s1_qp_reg      <= s1_qp_next;
            s1_mass_reg[0] <= a_mass_inertia;
            s1_mass_reg[1] <= b_mass_inertia;
            s1_old_reg     <= impulse_sum_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation matrices, spin cross arm, arm cross direction
    // ------------------------------------------------------------------
    logic               s2_valid_reg;
    logic signed [19:0] s2_m_reg  [2][9];
    logic signed [19:0] s2_m_next [2][9];
    logic signed [33:0] s2_x_reg  [2][3];
    logic signed [33:0] s2_x_next [2][3];
    logic signed [33:0] s2_c_reg  [2][3];
    logic signed [33:0] s2_c_next [2][3];
    logic signed [16:0] s2_dv_reg [3];
    logic [63:0]        s2_mass_reg [2];
    logic signed [31:0] s2_old_reg;

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            s2_m_next[b][0] = rot_diag(s1_qp_reg[b][P_YY], s1_qp_reg[b][P_ZZ]);
            s2_m_next[b][1] = rot_off(s1_qp_reg[b][P_XY], s1_qp_reg[b][P_ZW], 1'b0);
            s2_m_next[b][2] = rot_off(s1_qp_reg[b][P_XZ], s1_qp_reg[b][P_YW], 1'b1);
            s2_m_next[b][3] = rot_off(s1_qp_reg[b][P_XY], s1_qp_reg[b][P_ZW], 1'b1);
            s2_m_next[b][4] = rot_diag(s1_qp_reg[b][P_XX], s1_qp_reg[b][P_ZZ]);
            s2_m_next[b][5] = rot_off(s1_qp_reg[b][P_YZ], s1_qp_reg[b][P_XW], 1'b0);
            s2_m_next[b][6] = rot_off(s1_qp_reg[b][P_XZ], s1_qp_reg[b][P_YW], 1'b0);
            s2_m_next[b][7] = rot_off(s1_qp_reg[b][P_YZ], s1_qp_reg[b][P_XW], 1'b1);
            s2_m_next[b][8] = rot_diag(s1_qp_reg[b][P_XX], s1_qp_reg[b][P_YY]);
            for (int i = 0; i < 3; i++)
            begin
                s2_x_next[b][i] = cross_term(17'(s1_w_reg[b][NXT[i]]), s1_r_reg[b][PRV[i]],
                                             17'(s1_w_reg[b][PRV[i]]), s1_r_reg[b][NXT[i]]);
                s2_c_next[b][i] = cross_term(s1_r_reg[b][NXT[i]], 17'(dir_l[PRV[i]]),
                                             s1_r_reg[b][PRV[i]], 17'(dir_l[NXT[i]]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_m_reg    <= s2_m_next;
            s2_x_reg    <= s2_x_next;
            s2_c_reg    <= s2_c_next;
            s2_dv_reg   <= s1_dv_reg;
            s2_mass_reg <= s1_mass_reg;
            s2_old_reg  <= s1_old_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: relative velocity, u = R^T c before scaling
    // ------------------------------------------------------------------
    logic               s3_valid_reg;
    logic signed [35:0] s3_rel_reg  [3];
    logic signed [35:0] s3_rel_next [3];
    logic signed [55:0] s3_up_reg  [2][3];
    logic signed [55:0] s3_up_next [2][3];
    logic [63:0]        s3_mass_reg [2];
    logic signed [31:0] s3_old_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_rel_next[i] = (36'(s2_dv_reg[i]) <<< 8) + 36'(s2_x_reg[1][i])
                             - 36'(s2_x_reg[0][i]);
        end
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_up_next[b][i] = 56'(s2_m_reg[b][i])     * 56'(s2_c_reg[b][0])
                                 + 56'(s2_m_reg[b][3 + i]) * 56'(s2_c_reg[b][1])
                                 + 56'(s2_m_reg[b][6 + i]) * 56'(s2_c_reg[b][2]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_rel_reg  <= s3_rel_next;
            s3_up_reg   <= s3_up_next;
            s3_mass_reg <= s2_mass_reg;
            s3_old_reg  <= s2_old_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: projection on direction, saturated |u|
    // ------------------------------------------------------------------
    logic               s4_valid_reg;
    logic signed [53:0] s4_proj_reg;
    logic signed [53:0] s4_proj_next;
    logic [31:0]        s4_mag_reg  [2][3];
    logic [31:0]        s4_mag_next [2][3];
    logic [63:0]        s4_mass_reg [2];
    logic signed [31:0] s4_old_reg;

    always_comb
    begin
        s4_proj_next = 54'(s3_rel_reg[0]) * 54'(dir_l[0])
                     + 54'(s3_rel_reg[1]) * 54'(dir_l[1])
                     + 54'(s3_rel_reg[2]) * 54'(dir_l[2]);
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_mag_next[b][i] = sat_abs(s3_up_reg[b][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_proj_reg <= s4_proj_next;
            s4_mag_reg  <= s4_mag_next;
            s4_mass_reg <= s3_mass_reg;
            s4_old_reg  <= s3_old_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: speed error, squared |u|
    // ------------------------------------------------------------------
    logic               s5_valid_reg;
    logic [46:0]        s5_emag_reg;
    logic [46:0]        s5_emag_next;
    logic               s5_epos_reg;
    logic               s5_epos_next;
    logic [46:0]        s5_sq_reg  [2][3];
    logic [46:0]        s5_sq_next [2][3];
    logic [63:0]        s5_mass_reg [2];
    logic signed [31:0] s5_old_reg;
    logic signed [54:0] s5_ew;
    logic signed [46:0] s5_err;
    logic [63:0]        s5_p [2][3];

    always_comb
    begin
        s5_ew        = 55'(s4_proj_reg) - (55'(desired_speed_reg) <<< 8);
        s5_err       = s5_ew[54:8];
        s5_epos_next = !s5_err[46] && (s5_err != '0);
        s5_emag_next = s5_err[46] ? 47'(-s5_err) : 47'(s5_err);
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_p[b][i]       = {32'b0, s4_mag_reg[b][i]} * {32'b0, s4_mag_reg[b][i]};
                s5_sq_next[b][i] = s5_p[b][i][62:16];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_emag_reg <= s5_emag_next;
            s5_epos_reg <= s5_epos_next;
            s5_sq_reg   <= s5_sq_next;
            s5_mass_reg <= s4_mass_reg;
            s5_old_reg  <= s4_old_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: inertia terms, linear mass sum
    // ------------------------------------------------------------------
    logic               s6_valid_reg;
    logic [50:0]        s6_t_reg  [2][3];
    logic [50:0]        s6_t_next [2][3];
    logic [20:0]        s6_msum_reg;
    logic [20:0]        s6_msum_next;
    logic [46:0]        s6_emag_reg;
    logic               s6_epos_reg;
    logic signed [31:0] s6_old_reg;
    logic [63:0]        s6_p [2][3];

    always_comb
    begin
        s6_msum_next = (21'(s5_mass_reg[0][15:0]) + 21'(s5_mass_reg[1][15:0])) << 4;
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_p[b][i]      = 64'(s5_mass_reg[b][16*(i+1) +: 16]) * 64'(s5_sq_reg[b][i]);
                s6_t_next[b][i] = s6_p[b][i][62:12];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (adv)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_t_reg    <= s6_t_next;
            s6_msum_reg <= s6_msum_next;
            s6_emag_reg <= s5_emag_reg;
            s6_epos_reg <= s5_epos_reg;
            s6_old_reg  <= s5_old_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: per-body angular sums
    // ------------------------------------------------------------------
    logic               s7_valid_reg;
    logic [52:0]        s7_ts_reg  [2];
    logic [52:0]        s7_ts_next [2];
    logic [20:0]        s7_msum_reg;
    logic [46:0]        s7_emag_reg;
    logic               s7_epos_reg;
    logic signed [31:0] s7_old_reg;

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            s7_ts_next[b] = 53'(s6_t_reg[b][0]) + 53'(s6_t_reg[b][1]) + 53'(s6_t_reg[b][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (adv)
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_ts_reg   <= s7_ts_next;
            s7_msum_reg <= s6_msum_reg;
            s7_emag_reg <= s6_emag_reg;
            s7_epos_reg <= s6_epos_reg;
            s7_old_reg  <= s6_old_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: effective mass, rigid and overflow decisions, dividend
    // ------------------------------------------------------------------
    logic             s8_valid_reg;
    logic [REM_W-1:0] s8_rem_reg;
    logic [REM_W-1:0] s8_rem_next;
    logic [K_W-1:0]   s8_k_reg;
    logic [K_W-1:0]   s8_k_next;
    div_side_t        s8_side_reg;
    div_side_t        s8_side_next;

    always_comb
    begin
        s8_k_next            = K_W'(s7_ts_reg[0]) + K_W'(s7_ts_reg[1]) + K_W'(s7_msum_reg);
        s8_rem_next          = REM_W'(s7_emag_reg) << 16;
        s8_side_next.old     = s7_old_reg;
        s8_side_next.err_pos = s7_epos_reg;
        s8_side_next.rigid   = (s8_k_next == '0) || (s8_k_next < K_W'(rigid_threshold_reg));
        s8_side_next.ovf     = K_W'(s7_emag_reg >> 18) >= s8_k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else if (adv)
            s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_rem_reg  <= s8_rem_next;
            s8_k_reg    <= s8_k_next;
            s8_side_reg <= s8_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: |error| << 16 / K, one quotient bit per stage
    // ------------------------------------------------------------------
    logic             dv_vld;
    logic [QUO_W-1:0] dv_quo;
    div_side_t        dv_side;

    vci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s8_valid_reg),
        .in_rem   (s8_rem_reg),
        .in_k     (s8_k_reg),
        .in_side  (s8_side_reg),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // ------------------------------------------------------------------
    // Stage 9: accumulate, saturate, clamp to the minimum
    // ------------------------------------------------------------------
    logic               s9_valid_reg;
    logic signed [31:0] s9_sum_reg;
    logic signed [31:0] s9_sum_next;
    logic signed [32:0] s9_app_reg;
    logic signed [32:0] s9_app_next;
    logic               s9_rigid_reg;
    logic [QUO_W-1:0]   s9_qe;
    logic signed [35:0] s9_qs;
    logic signed [35:0] s9_delta;
    logic signed [35:0] s9_tot;

    always_comb
    begin
        s9_qe = dv_side.ovf ? '1 : dv_quo;
        s9_qs = $signed({2'b00, s9_qe});
        if (dv_side.rigid)
            s9_delta = '0;
        else if (dv_side.err_pos)
            s9_delta = -s9_qs;
        else
            s9_delta = s9_qs;
        s9_tot = 36'(dv_side.old) + s9_delta;
        if (s9_tot > SAT_MAX36)
            s9_sum_next = 32'sh7fff_ffff;
        else if (s9_tot < SAT_MIN36)
            s9_sum_next = 32'sh8000_0000;
        else
            s9_sum_next = s9_tot[31:0];
        if (s9_sum_next < min_impulse_reg)
            s9_sum_next = min_impulse_reg;
        s9_app_next = 33'(s9_sum_next) - 33'(dv_side.old);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_valid_reg <= 1'b0;
        else if (adv)
            s9_valid_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_sum_reg   <= s9_sum_next;
            s9_app_reg   <= s9_app_next;
            s9_rigid_reg <= dv_side.rigid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: applied impulse vector, output register
    // ------------------------------------------------------------------
    logic signed [31:0] s10_imp_reg  [3];
    logic signed [31:0] s10_imp_next [3];
    logic signed [31:0] s10_sum_reg;
    logic               s10_rigid_reg;
    logic signed [48:0] s10_p [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s10_p[i] = (49'(dir_l[i]) * 49'(s9_app_reg)) >>> 8;
            if (s10_p[i] > SAT_MAX49)
                s10_imp_next[i] = 32'sh7fff_ffff;
            else if (s10_p[i] < SAT_MIN49)
                s10_imp_next[i] = 32'sh8000_0000;
            else
                s10_imp_next[i] = s10_p[i][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s10_valid_reg <= 1'b0;
        else if (adv)
            s10_valid_reg <= s9_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_imp_reg   <= s10_imp_next;
            s10_sum_reg   <= s9_sum_reg;
            s10_rigid_reg <= s9_rigid_reg;
        end
    end

    assign out_valid       = s10_valid_reg;
    assign impulse_x       = s10_imp_reg[0];
    assign impulse_y       = s10_imp_reg[1];
    assign impulse_z       = s10_imp_reg[2];
    assign impulse_sum_out = s10_sum_reg;
    assign rigid_flag      = s10_rigid_reg;

    // Accumulated impulse never ends below the configured minimum
    a_sum_above_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> impulse_sum_out >= min_impulse_reg)
        else $error("accumulated impulse below minimum");

    // A zero x lane of the direction gives no x impulse
    a_zero_dir_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (direction_reg[15:0] == 16'd0) |-> impulse_x == 32'sd0)
        else $error("impulse on zero direction lane");

    // A rigid step only moves the sum when the minimum clamp lifts it
    a_rigid_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        s9_valid_reg && s9_rigid_reg && (s9_app_reg != 33'sd0)
        |-> s9_sum_reg == min_impulse_reg)
        else $error("rigid step changed impulse without clamp");

endmodule

>>> src/vci_div.sv
`timescale 1ns / 1ps
module vci_div
    import vci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [REM_W-1:0] in_rem,
    input  logic [K_W-1:0]   in_k,
    input  div_side_t        in_side,
    output logic             out_vld,
    output logic [QUO_W-1:0] out_quo,
    output div_side_t        out_side
);

    logic             vld_reg  [QUO_W];
    logic [REM_W-1:0] rem_reg  [QUO_W];
    logic [K_W-1:0]   k_reg    [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    div_side_t        side_reg [QUO_W];

    logic [REM_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int BIT = QUO_W - 1 - s;

        logic             vld_prev;
        logic [REM_W-1:0] rem_prev;
        logic [K_W-1:0]   k_prev;
        logic [QUO_W-1:0] quo_prev;
        div_side_t        side_prev;
        logic             take;

        if (s == 0) begin : g_first
            assign vld_prev  = in_vld;
            assign rem_prev  = in_rem;
            assign k_prev    = in_k;
            assign quo_prev  = '0;
            assign side_prev = in_side;
        end
        else begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign k_prev    = k_reg[s-1];
            assign quo_prev  = quo_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        // Resolve one quotient bit: subtract the shifted divisor when it fits
        assign take        = (rem_prev >> BIT) >= REM_W'(k_prev);
        assign rem_next[s] = take ? (rem_prev - (REM_W'(k_prev) << BIT)) : rem_prev;
        assign quo_next[s] = {quo_prev[QUO_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next[s];
                k_reg[s]    <= k_prev;
                quo_reg[s]  <= quo_next[s];
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign out_quo  = quo_reg[QUO_W-1];
    assign out_side = side_reg[QUO_W-1];

    // Final remainder stays below the divisor whenever the quotient fit
    a_rem_below_k: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_side.ovf && !out_side.rigid
        |-> rem_reg[QUO_W-1] < REM_W'(k_reg[QUO_W-1]))
        else $error("divider remainder not below divisor");

endmodule
